// ----- hdl/ortt_pkg.sv -----
// Shared types and constants for the outstanding result tracker table.
// Used by ortt_ctrl, ortt_dpath, the top level and the port checker.
`timescale 1ns / 1ps

package ortt_pkg;

  localparam int CNT_W      = 6;
  localparam int ID_W       = 32;
  localparam int TIME_W     = 64;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = 64'd1000000000;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TRACKING_ENABLE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STALE_AGE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_MARK     = 2'd1,
    REQ_CHECK    = 2'd2,
    REQ_CLEANUP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              handled;
    logic              error;
    logic [TIME_W-1:0] created;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic final_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enabled;
    logic slot_free;
    logic scan_done;
  } dp_stat_t;

endpackage

// ----- hdl/ortt_ctrl.sv -----
// Request sequencer for the tracker table: accept, table scan, final item.
// Depends on ortt_pkg; drives ortt_dpath through dp_cmd_t / dp_stat_t.
`timescale 1ns / 1ps

module ortt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_type,
  output logic               in_ready,
  output ortt_pkg::dp_cmd_t  cmd,
  input  ortt_pkg::dp_stat_t stat
);

  ortt_pkg::state_t state;
  ortt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ortt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ortt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // register and disabled requests skip the table scan
          if (!stat.enabled || ortt_pkg::req_t'(in_type) == ortt_pkg::REQ_REGISTER) begin
            state_next = ortt_pkg::ST_DONE;
          end else begin
            state_next = ortt_pkg::ST_SCAN;
          end
        end
      end
      ortt_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = ortt_pkg::ST_DONE;
        end
      end
      ortt_pkg::ST_DONE: begin
        if (stat.slot_free) begin
          cmd.final_load = 1'b1;
          state_next     = ortt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ortt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ortt_dpath.sv -----
// Datapath of the tracker table: entry memory, scan pipeline, config
// registers and the output register. Depends on ortt_pkg.
`timescale 1ns / 1ps

module ortt_dpath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ortt_pkg::dp_cmd_t               cmd,
  output ortt_pkg::dp_stat_t              stat,
  input  logic [1:0]                      in_type,
  input  logic                            in_is_error,
  input  logic [ortt_pkg::ID_W-1:0]       in_target_id,
  input  logic [ortt_pkg::TIME_W-1:0]     in_now_time,
  input  logic                            cfg_we,
  input  logic [ortt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ortt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [ortt_pkg::ID_W-1:0]       out_id,
  output logic [ortt_pkg::TIME_W-1:0]     out_age,
  output logic                            out_stale,
  output logic [ortt_pkg::CNT_W-1:0]      out_count,
  output logic                            out_last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [ortt_pkg::CNT_W-1:0] DEPTH_CNT = ortt_pkg::CNT_W'(TABLE_DEPTH);

  ortt_pkg::entry_t mem [TABLE_DEPTH];
  ortt_pkg::entry_t rd_data;

  logic                          tracking_enable;
  logic [ortt_pkg::TIME_W-1:0]   stale_age_limit;
  logic [ortt_pkg::CNT_W-1:0]    occupancy;
  logic [ortt_pkg::ID_W-1:0]     next_id;

  ortt_pkg::req_t                req_type;
  logic [ortt_pkg::ID_W-1:0]     req_target;
  logic [ortt_pkg::TIME_W-1:0]   req_now;
  ortt_pkg::status_t             fin_status;
  logic [ortt_pkg::ID_W-1:0]     fin_id;

  logic [ortt_pkg::CNT_W-1:0]    rd_idx;    // next address to read
  logic [IDX_W-1:0]              ev_idx;    // address of rd_data
  logic                          ev_valid;  // rd_data holds a live entry
  logic [ortt_pkg::CNT_W-1:0]    wr_ptr;    // compaction write pointer

  logic                          slot_free;
  logic                          scan_ev;
  logic [ortt_pkg::TIME_W-1:0]   entry_age;
  logic                          is_stale;
  logic                          mark_hit;
  logic                          stale_emit;
  logic                          scan_stall;
  logic                          scan_adv;
  logic                          rd_en;
  logic                          move_en;
  logic                          reg_go;
  logic                          table_full;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  ortt_pkg::entry_t              mem_wdata;

  assign slot_free  = !out_valid || out_ready;
  assign scan_ev    = cmd.scan_en && ev_valid;
  assign entry_age  = req_now - rd_data.created;
  assign is_stale   = !rd_data.handled && rd_data.error && (entry_age > stale_age_limit);
  assign mark_hit   = scan_ev && req_type == ortt_pkg::REQ_MARK && rd_data.id == req_target;
  assign stale_emit = scan_ev && req_type == ortt_pkg::REQ_CHECK && is_stale;
  assign scan_stall = stale_emit && !slot_free;
  assign scan_adv   = cmd.scan_en && !scan_stall && !mark_hit;
  assign rd_en      = scan_adv && (rd_idx < occupancy);
  assign move_en    = scan_ev && req_type == ortt_pkg::REQ_CLEANUP && !rd_data.handled;
  assign table_full = occupancy >= DEPTH_CNT;
  assign reg_go     = cmd.accept && tracking_enable && !table_full &&
                      ortt_pkg::req_t'(in_type) == ortt_pkg::REQ_REGISTER;

  assign stat.enabled   = tracking_enable;
  assign stat.slot_free = slot_free;
  assign stat.scan_done = mark_hit || (cmd.scan_en && !ev_valid && rd_idx >= occupancy);

  // single write port: append, mark or compaction move, never together
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = occupancy[IDX_W-1:0];
    mem_wdata = rd_data;
    priority if (reg_go) begin
      mem_we            = 1'b1;
      mem_wdata.id      = next_id;
      mem_wdata.handled = 1'b0;
      mem_wdata.error   = in_is_error;
      mem_wdata.created = in_now_time;
    end else if (mark_hit) begin
      mem_we            = 1'b1;
      mem_waddr         = ev_idx;
      mem_wdata.handled = 1'b1;
    end else if (move_en) begin
      mem_we    = 1'b1;
      mem_waddr = wr_ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b1;
      stale_age_limit <= ortt_pkg::STALE_LIMIT_RESET;
      occupancy       <= '0;
      next_id         <= '0;
      ev_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ortt_pkg::CFG_TRACKING_ENABLE: tracking_enable <= cfg_wdata[0];
          ortt_pkg::CFG_STALE_AGE_LIMIT: stale_age_limit <= cfg_wdata;
          default: ;
        endcase
      end
      if (reg_go) begin
        occupancy <= occupancy + 1'b1;
        next_id   <= next_id + 1'b1;
      end else if (stat.scan_done && req_type == ortt_pkg::REQ_CLEANUP) begin
        occupancy <= wr_ptr;
      end
      if (cmd.accept) begin
        ev_valid <= 1'b0;
      end else if (scan_adv) begin
        ev_valid <= rd_en;
      end
      if ((stale_emit && slot_free) || cmd.final_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request context and scan counters
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type   <= ortt_pkg::req_t'(in_type);
      req_target <= in_target_id;
      req_now    <= in_now_time;
      rd_idx     <= '0;
      wr_ptr     <= '0;
      if (!tracking_enable) begin
        fin_status <= ortt_pkg::STAT_OK;
        fin_id     <= '0;
      end else begin
        unique case (ortt_pkg::req_t'(in_type))
          ortt_pkg::REQ_REGISTER: begin
            fin_status <= table_full ? ortt_pkg::STAT_FULL : ortt_pkg::STAT_OK;
            fin_id     <= table_full ? '0 : next_id;
          end
          ortt_pkg::REQ_MARK: begin
            fin_status <= ortt_pkg::STAT_NOT_FOUND;
            fin_id     <= in_target_id;
          end
          default: begin
            fin_status <= ortt_pkg::STAT_OK;
            fin_id     <= '0;
          end
        endcase
      end
    end else begin
      if (mark_hit) begin
        fin_status <= ortt_pkg::STAT_OK;
      end
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
        ev_idx <= rd_idx[IDX_W-1:0];
      end
      if (move_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (stale_emit && slot_free) begin
      out_status <= ortt_pkg::STAT_OK;
      out_id     <= rd_data.id;
      out_age    <= entry_age;
      out_stale  <= 1'b1;
      out_count  <= occupancy;
      out_last   <= 1'b0;
    end else if (cmd.final_load) begin
      out_status <= fin_status;
      out_id     <= fin_id;
      out_age    <= '0;
      out_stale  <= 1'b0;
      out_count  <= occupancy;
      out_last   <= 1'b1;
    end
  end

endmodule

// ----- hdl/outstanding_result_tracker_table_core.sv -----
// Outstanding result tracker table, top level: stream ports, config port.
// Depends on ortt_pkg, ortt_ctrl and ortt_dpath.
//
// Usage:
//   Requests arrive on the s_axis channel (tuser = request kind), results
//   leave on m_axis. Every request gives one result with tlast set; a check
//   request first gives one transfer per stale unhandled error entry
//   (tuser = 1, tlast = 0) in table order, then its closing transfer.
//   Requests are taken one at a time: s_axis_tready is high only while the
//   sequencer is idle, but that includes the time a finished result still
//   sits in the output register waiting for m_axis_tready.
// Sequence: a register or disabled request goes from the accept straight to
//   the DONE state, which loads the closing result into the output register.
//   mark, check, cleanup: the scan reads one entry per cycle, while no stale
//   report waits for m_axis_tready, from the single read port of the entry
//   memory, and mark stops at the first match; the closing result loads in
//   the DONE state after the scan.
// Stalls: while a stale report waits for m_axis_tready the scan holds its
//   place; nothing is dropped.
// Reset (rst, synchronous): empties the table, id counter to zero,
//   tracking enabled, stale limit 1e9. No memory clearing pass is needed.
// Config: cfg_we with cfg_addr 0 = tracking_enable (bit 0),
//   1 = stale_age_limit; write only while the block is idle.
`timescale 1ns / 1ps

module outstanding_result_tracker_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] is_error, [32:1] target_id, [96:33] now_time, [103:97] zero
  input  logic [ortt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                          s_axis_tuser,
  // result channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [33:2] entry_id, [97:34] entry_age, [103:98] live_count
  output logic [ortt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] stale_report
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ortt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ortt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ortt_pkg::dp_cmd_t  cmd;
  ortt_pkg::dp_stat_t stat;

  logic [1:0]                    out_status;
  logic [ortt_pkg::ID_W-1:0]     out_id;
  logic [ortt_pkg::TIME_W-1:0]   out_age;
  logic                          out_stale;
  logic [ortt_pkg::CNT_W-1:0]    out_count;

  ortt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_type  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ortt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_type      (s_axis_tuser),
    .in_is_error  (s_axis_tdata[0]),
    .in_target_id (s_axis_tdata[32:1]),
    .in_now_time  (s_axis_tdata[96:33]),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_age      (out_age),
    .out_stale    (out_stale),
    .out_count    (out_count),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_age, out_id, out_status};
  assign m_axis_tuser = out_stale;

endmodule

// ----- hdl/ortt_checker.sv -----
// Port-level checks for the tracker table top level, plus the bind that
// attaches them. Depends on ortt_pkg and the top level.
`timescale 1ns / 1ps

module ortt_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ortt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);

  // a result waiting on the receiver holds steady
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a stale report is never the closing transfer and always reports ok
  a_stale_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      !m_axis_tlast && m_axis_tdata[1:0] == ortt_pkg::STAT_OK)
    else $error("malformed stale report");

  // occupancy never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[103:98] <= ortt_pkg::CNT_W'(TABLE_DEPTH))
    else $error("live count beyond table depth");

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind outstanding_result_tracker_table_core ortt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_ortt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
